// ===== rtl/mlf_pkg.sv =====
`default_nettype none

package mlf_pkg;

    // block geometry
    localparam int CHANNELS   = 8;
    localparam int LEVEL_BITS = 10;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // port field widths
    localparam int KIND_W      = 2;
    localparam int CH_W        = 3;
    localparam int LEVEL_W     = 10;
    localparam int TIME_W      = 32;
    localparam int RES_KIND_W  = 2;

    // progress arithmetic
    localparam int FRAC_BITS  = 16;
    localparam int PROG_W     = FRAC_BITS + 1;
    localparam int NUM_W      = TIME_W + FRAC_BITS + 1;
    localparam int DIFF_W     = LEVEL_BITS + 1;
    localparam int PROD_W     = DIFF_W + PROG_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int DIV_CNT_W  = $clog2(PROG_W + 1);

    localparam logic [TIME_W-1:0] MIN_FADE_MS = TIME_W'(10);

    // input item kinds
    localparam logic [KIND_W-1:0] K_STAGE = 2'd0;
    localparam logic [KIND_W-1:0] K_START = 2'd1;
    localparam logic [KIND_W-1:0] K_STOP  = 2'd2;
    localparam logic [KIND_W-1:0] K_TICK  = 2'd3;

    // result kinds
    localparam logic [RES_KIND_W-1:0] RES_LEVEL    = 2'd0;
    localparam logic [RES_KIND_W-1:0] RES_STARTED  = 2'd1;
    localparam logic [RES_KIND_W-1:0] RES_REJECTED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_RD,
        S_START_WR,
        S_ACK,
        S_CHECK,
        S_DIV,
        S_RD,
        S_MUL,
        S_LVL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] lvl_start;
        logic [LEVEL_BITS-1:0] lvl_end;
        logic [LEVEL_BITS-1:0] lvl_cur;
    } chan_word_t;

    typedef struct packed {
        logic                  stg_we;
        logic [CH_AW-1:0]      stg_addr;
        logic [LEVEL_BITS-1:0] stg_data;
        logic                  chan_we;
        logic [CH_AW-1:0]      chan_addr;
        chan_word_t            chan_data;
    } store_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mlf_level_store.sv =====
`default_nettype none

module mlf_level_store
    import mlf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire store_wr_t             wr,
    input  wire logic [CH_AW-1:0]      rd_addr,
    output logic      [LEVEL_BITS-1:0] staged_q,
    output chan_word_t                 chan_q
);

    // staged targets and per-channel fade words
    logic [LEVEL_BITS-1:0] stg_mem_reg [CHANNELS];
    chan_word_t            chan_mem_reg [CHANNELS];

    // staged and current levels read as zero until first written
    logic [CHANNELS-1:0]   stg_vld_reg;
    logic [CHANNELS-1:0]   cur_vld_reg;

    logic [LEVEL_BITS-1:0] stg_q_reg;
    logic                  stg_vq_reg;
    chan_word_t            chan_q_reg;
    logic                  cur_vq_reg;

    always_ff @(posedge clk)
    begin
        if (wr.stg_we)
        begin
            stg_mem_reg[wr.stg_addr] <= wr.stg_data;
        end
        if (wr.chan_we)
        begin
            chan_mem_reg[wr.chan_addr] <= wr.chan_data;
        end
        stg_q_reg  <= stg_mem_reg[rd_addr];
        chan_q_reg <= chan_mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
            cur_vld_reg <= '0;
            stg_vq_reg  <= 1'b0;
            cur_vq_reg  <= 1'b0;
        end
        else
        begin
            if (wr.stg_we)
            begin
                stg_vld_reg[wr.stg_addr] <= 1'b1;
            end
            if (wr.chan_we)
            begin
                cur_vld_reg[wr.chan_addr] <= 1'b1;
            end
            stg_vq_reg <= stg_vld_reg[rd_addr];
            cur_vq_reg <= cur_vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        staged_q = stg_vq_reg ? stg_q_reg : '0;
        chan_q   = chan_q_reg;
        if (!cur_vq_reg)
        begin
            chan_q.lvl_cur = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlf_progress_div.sv =====
`default_nettype none

module mlf_progress_div
    import mlf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [TIME_W-1:0] elapsed,
    input  wire logic [TIME_W-1:0] len,
    output logic                   done,
    output logic      [PROG_W-1:0] quot
);

    // restoring divide, one quotient bit a cycle; quotient fits PROG_W bits
    // because elapsed is below len
    logic [TIME_W-1:0]    rem_reg,  rem_next;
    logic [PROG_W-1:0]    low_reg,  low_next;
    logic [PROG_W-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [NUM_W-1:0]     num;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_sub;
    logic                 ge;

    always_comb
    begin
        num = NUM_W'({elapsed, {FRAC_BITS{1'b0}}}) + NUM_W'(len >> 1);
        trial     = {rem_reg, low_reg[PROG_W-1]};
        trial_sub = trial - {1'b0, len};
        ge        = (trial >= {1'b0, len});

        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (go)
        begin
            rem_next  = num[NUM_W-1:PROG_W];
            low_next  = num[PROG_W-1:0];
            quot_next = '0;
            cnt_next  = DIV_CNT_W'(PROG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            low_next  = {low_reg[PROG_W-2:0], 1'b0};
            quot_next = {quot_reg[PROG_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/multichannel_linear_fade_core.sv =====
`default_nettype none

// multi-channel linear brightness fader. stage transfers store one target level
// per channel; a start transfer cancels any running fade, rejects a duration
// under 10 ms (one rejected result), otherwise snapshots current levels as start
// and staged levels as end and returns one started result. a tick during a fade
// returns one level result per channel (last set on the highest channel): the
// end levels once the fade has run out, otherwise start + rounded
// (end - start) * progress, where progress = (elapsed * 65536 + dur / 2) / dur.
// start reads and writes each channel in turn, then returns its result; a tick
// while fading runs the bit-serial progress divider followed by a read,
// multiply, round and emit pass over the channel memory; an expiring tick skips
// the divider. input stall is high while an item is in work; the last result may
// wait in the output register while the next item is taken. no clearing pass is
// needed after reset.
module multichannel_linear_fade_core
    import mlf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [CH_W-1:0]       channel,
    input  wire logic [LEVEL_W-1:0]    level,
    input  wire logic [TIME_W-1:0]     span_ms,
    input  wire logic [TIME_W-1:0]     now_ms,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [RES_KIND_W-1:0] result_kind,
    output logic      [CH_W-1:0]       out_channel,
    output logic      [LEVEL_W-1:0]    out_level,
    output logic                       last
);

    // sequencer state
    state_t                 state_reg, state_next;
    logic [CH_AW-1:0]       ch_reg, ch_next;

    // fade state
    logic                   fading_reg, fading_next;
    logic [TIME_W-1:0]      fade_begin_reg, fade_begin_next;
    logic [TIME_W-1:0]      fade_len_reg, fade_len_next;

    // per-tick working values
    logic [TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic                   expire_reg, expire_next;
    logic [PROG_W-1:0]      prog_reg, prog_next;
    logic [RES_KIND_W-1:0]  ack_kind_reg, ack_kind_next;
    logic [LEVEL_BITS-1:0]  start_reg, start_next;
    logic [LEVEL_BITS-1:0]  end_reg, end_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [LEVEL_BITS-1:0]  lvl_reg, lvl_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [RES_KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [CH_W-1:0]        out_ch_reg, out_ch_next;
    logic [LEVEL_W-1:0]     out_level_reg, out_level_next;
    logic                   out_last_reg, out_last_next;

    // memory and divider hookup
    store_wr_t              store_wr;
    logic [LEVEL_BITS-1:0]  staged_q;
    chan_word_t             chan_q;
    logic                   div_go;
    logic                   div_done;
    logic [PROG_W-1:0]      div_quot;

    // misc combinational
    logic                   in_xfer;
    logic                   out_free;
    logic                   ch_last;
    logic                   expire_now;
    logic                   stage_ok;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROG_W:0]   prog_s;
    logic signed [PROD_W-1:0] prod_mul;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] prod_shr;

    mlf_level_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (store_wr),
        .rd_addr  (ch_reg),
        .staged_q (staged_q),
        .chan_q   (chan_q)
    );

    mlf_progress_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .elapsed (elapsed_reg),
        .len     (fade_len_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign ch_last    = (ch_reg == CH_AW'(CHANNELS - 1));
    assign expire_now = (elapsed_reg >= fade_len_reg) || (fade_len_reg == '0);
    assign stage_ok   = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));

    // level arithmetic: diff * progress, then round half up and add start
    assign diff     = $signed({1'b0, chan_q.lvl_end}) - $signed({1'b0, chan_q.lvl_start});
    assign prog_s   = $signed({1'b0, prog_reg});
    assign prod_mul = diff * prog_s;
    assign prod_rnd = prod_reg + PROD_W'(ROUND_HALF);
    assign prod_shr = prod_rnd >>> FRAC_BITS;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == K_START)
                    begin
                        state_next = (span_ms < MIN_FADE_MS) ? S_ACK : S_START_RD;
                    end
                    else if ((kind == K_TICK) && fading_reg)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_START_RD: state_next = S_START_WR;
            S_START_WR: state_next = ch_last ? S_ACK : S_START_RD;
            S_ACK:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:    state_next = expire_now ? S_RD : S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:       state_next = S_MUL;
            S_MUL:      state_next = S_LVL;
            S_LVL:      state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ch_last ? S_IDLE : S_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ch_next         = ch_reg;
        fading_next     = fading_reg;
        fade_begin_next = fade_begin_reg;
        fade_len_next   = fade_len_reg;
        elapsed_next    = elapsed_reg;
        expire_next     = expire_reg;
        prog_next       = prog_reg;
        ack_kind_next   = ack_kind_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        prod_next       = prod_reg;
        lvl_next        = lvl_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_ch_next     = out_ch_reg;
        out_level_next  = out_level_reg;
        out_last_next   = out_last_reg;

        store_wr        = '0;
        div_go          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ch_next = '0;
                if (in_xfer)
                begin
                    case (kind)
                        K_STAGE:
                        begin
                            store_wr.stg_we   = stage_ok;
                            store_wr.stg_addr = channel[CH_AW-1:0];
                            store_wr.stg_data = level[LEVEL_BITS-1:0];
                        end
                        K_START:
                        begin
                            fading_next = 1'b0;
                            if (span_ms < MIN_FADE_MS)
                            begin
                                ack_kind_next = RES_REJECTED;
                            end
                            else
                            begin
                                ack_kind_next   = RES_STARTED;
                                fade_begin_next = now_ms;
                                fade_len_next   = span_ms;
                            end
                        end
                        K_STOP:
                        begin
                            fading_next = 1'b0;
                        end
                        K_TICK:
                        begin
                            // wrapping subtract: a time running backwards expires
                            elapsed_next = now_ms - fade_begin_reg;
                        end
                        default:
                        begin
                            fading_next = fading_reg;
                        end
                    endcase
                end
            end
            S_START_WR:
            begin
                // start takes the current level, end takes the staged target
                store_wr.chan_we             = 1'b1;
                store_wr.chan_addr           = ch_reg;
                store_wr.chan_data.lvl_start = chan_q.lvl_cur;
                store_wr.chan_data.lvl_end   = staged_q;
                store_wr.chan_data.lvl_cur   = chan_q.lvl_cur;
                if (ch_last)
                begin
                    fading_next = 1'b1;
                end
                else
                begin
                    ch_next = ch_reg + CH_AW'(1);
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = ack_kind_reg;
                    out_ch_next    = '0;
                    out_level_next = '0;
                    out_last_next  = 1'b1;
                end
            end
            S_CHECK:
            begin
                expire_next = expire_now;
                if (expire_now)
                begin
                    fading_next = 1'b0;
                end
                else
                begin
                    div_go = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    prog_next = div_quot;
                end
            end
            S_MUL:
            begin
                start_next = chan_q.lvl_start;
                end_next   = chan_q.lvl_end;
                prod_next  = prod_mul;
            end
            S_LVL:
            begin
                lvl_next = expire_reg ? end_reg
                                      : start_reg + prod_shr[LEVEL_BITS-1:0];
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_kind_next                = RES_LEVEL;
                    out_ch_next                  = CH_W'(ch_reg);
                    out_level_next               = LEVEL_W'(lvl_reg);
                    out_last_next                = ch_last;
                    store_wr.chan_we             = 1'b1;
                    store_wr.chan_addr           = ch_reg;
                    store_wr.chan_data.lvl_start = start_reg;
                    store_wr.chan_data.lvl_end   = end_reg;
                    store_wr.chan_data.lvl_cur   = lvl_reg;
                    if (!ch_last)
                    begin
                        ch_next = ch_reg + CH_AW'(1);
                    end
                end
            end
            default:
            begin
                ch_next = ch_reg;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg    <= elapsed_next;
        prog_reg       <= prog_next;
        ack_kind_reg   <= ack_kind_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        prod_reg       <= prod_next;
        lvl_reg        <= lvl_next;
        expire_reg     <= expire_next;
        out_kind_reg   <= out_kind_next;
        out_ch_reg     <= out_ch_next;
        out_level_reg  <= out_level_next;
        out_last_reg   <= out_last_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ch_reg         <= '0;
            fading_reg     <= 1'b0;
            fade_begin_reg <= '0;
            fade_len_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            fading_reg     <= fading_next;
            fade_begin_reg <= fade_begin_next;
            fade_len_reg   <= fade_len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_channel = out_ch_reg;
    assign out_level   = out_level_reg;
    assign last        = out_last_reg;

`ifndef ASSERT_OFF
    // divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("progress divide finished outside the divide wait");

    // channel sweep never runs past the last channel
    a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ch_reg} < (CH_AW + 1)'(CHANNELS)))
        else $error("channel counter out of range");

    // status results are always the single final result of their item
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind != RES_LEVEL)) |-> last)
        else $error("start status result without last");

    // the channel memory is never written while waiting for a transfer
    a_no_chan_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.chan_we |-> (state_reg == S_START_WR || state_reg == S_EMIT))
        else $error("channel memory written outside a sweep");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_multichannel_linear_fade_core.sv =====
`timescale 1ns / 1ps

module tb_multichannel_linear_fade_core
    import mlf_pkg::*;
();

    // timing and run length
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 145;
    localparam int IDLE_PCT     = 15;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;

    // how a table row states its expectation
    localparam int FROM_PREDICTOR = -1;
    localparam int NO_RESULT      = 0;
    localparam int ONE_RESULT     = 1;

    typedef struct packed {
        logic [RES_KIND_W-1:0] rkind;
        logic [CH_W-1:0]       ch;
        logic [LEVEL_W-1:0]    lvl;
        logic                  fin;
    } fade_result_t;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [CH_W-1:0]       ch;
        logic [LEVEL_W-1:0]    lvl;
        logic [TIME_W-1:0]     dur;
        logic [TIME_W-1:0]     now;
        int                    typed_n;
        logic [RES_KIND_W-1:0] typed_kind;
    } stim_row_t;

    // block ports
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [KIND_W-1:0]     kind        = K_STAGE;
    logic [CH_W-1:0]       channel     = '0;
    logic [LEVEL_W-1:0]    level       = '0;
    logic [TIME_W-1:0]     span_ms     = '0;
    logic [TIME_W-1:0]     now_ms      = '0;
    logic                  out_stall   = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [RES_KIND_W-1:0] result_kind;
    logic [CH_W-1:0]       out_channel;
    logic [LEVEL_W-1:0]    out_level;
    logic                  res_last;

    // fader shadow state, kept in step with every accepted transfer
    logic [LEVEL_BITS-1:0] staged_lvl [CHANNELS];
    logic [LEVEL_BITS-1:0] from_lvl   [CHANNELS];
    logic [LEVEL_BITS-1:0] to_lvl     [CHANNELS];
    logic [LEVEL_BITS-1:0] shown_lvl  [CHANNELS];
    logic                  fade_on;
    logic [TIME_W-1:0]     fade_t0;
    logic [TIME_W-1:0]     fade_len;

    fade_result_t fresh_levels [$];    // results of the transfer just taken
    fade_result_t awaited_levels [$];  // results still owed by the block
    stim_row_t    directed_rows [$];

    // run bookkeeping
    int  mismatches      = 0;
    int  results_checked = 0;
    int  items_done      = 0;
    int  fades_started   = 0;
    int  starts_rejected = 0;
    int  fades_expired   = 0;
    int  mid_ticks       = 0;
    int  cycle_count     = 0;
    bit  calm            = 1'b0;
    int  hold_asked      = 0;
    int  hold_given      = 0;
    int  hold_left       = 0;

    multichannel_linear_fade_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .channel     (channel),
        .level       (level),
        .span_ms     (span_ms),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_channel (out_channel),
        .out_level   (out_level),
        .last        (res_last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                 awaited_levels.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // works out what one accepted transfer does to the fader and what it returns
    function automatic void advance_fader(input logic [KIND_W-1:0] k,
                                          input logic [CH_W-1:0] c,
                                          input logic [LEVEL_W-1:0] l,
                                          input logic [TIME_W-1:0] d,
                                          input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0]     elapsed;
        longint unsigned       progress;
        longint                diff;
        longint                lvl_wide;
        logic [LEVEL_BITS-1:0] lvl_now;
        fresh_levels.delete();
        case (k)
            K_STAGE:
            begin
                if (c < CHANNELS)
                    staged_lvl[c] = l[LEVEL_BITS-1:0];
            end
            K_STOP:
            begin
                fade_on = 1'b0;
            end
            K_START:
            begin
                // any running fade is dropped before the duration is looked at
                fade_on = 1'b0;
                if (d < MIN_FADE_MS)
                begin
                    fresh_levels.push_back('{RES_REJECTED, '0, '0, 1'b1});
                    starts_rejected++;
                end
                else
                begin
                    fade_t0  = t;
                    fade_len = d;
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        from_lvl[i] = shown_lvl[i];
                        to_lvl[i]   = staged_lvl[i];
                    end
                    fade_on = 1'b1;
                    fresh_levels.push_back('{RES_STARTED, '0, '0, 1'b1});
                    fades_started++;
                end
            end
            default:
            begin
                if (fade_on)
                begin
                    // wraps modulo 2^32, so time running backwards reads as expired
                    elapsed = t - fade_t0;
                    if (elapsed >= fade_len)
                    begin
                        fade_on = 1'b0;
                        for (int i = 0; i < CHANNELS; i++)
                            shown_lvl[i] = to_lvl[i];
                        fades_expired++;
                    end
                    else
                    begin
                        progress = (64'(elapsed) * 64'd65536 + 64'(fade_len >> 1))
                                   / 64'(fade_len);
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            diff     = longint'(to_lvl[i]) - longint'(from_lvl[i]);
                            // arithmetic shift floors, so halves round upwards
                            lvl_wide = longint'(from_lvl[i])
                                       + ((diff * longint'(progress) + 32768) >>> 16);
                            lvl_now  = LEVEL_BITS'(lvl_wide);
                            shown_lvl[i] = lvl_now;
                        end
                        mid_ticks++;
                    end
                    for (int i = 0; i < CHANNELS; i++)
                        fresh_levels.push_back('{RES_LEVEL, CH_W'(i),
                                                 LEVEL_W'(shown_lvl[i]),
                                                 i == CHANNELS - 1});
                end
            end
        endcase
    endfunction

    function automatic stim_row_t stim_row(input logic [KIND_W-1:0] k,
                                           input logic [CH_W-1:0] c,
                                           input logic [LEVEL_W-1:0] l,
                                           input logic [TIME_W-1:0] d,
                                           input logic [TIME_W-1:0] t,
                                           input int n,
                                           input logic [RES_KIND_W-1:0] rk);
        stim_row_t r;
        r.kind       = k;
        r.ch         = c;
        r.lvl        = l;
        r.dur        = d;
        r.now        = t;
        r.typed_n    = n;
        r.typed_kind = rk;
        return r;
    endfunction

    // offers one transfer, waits for it to be taken, then books its results
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] c,
                             input logic [LEVEL_W-1:0] l, input logic [TIME_W-1:0] d,
                             input logic [TIME_W-1:0] t, input int typed_n,
                             input logic [RES_KIND_W-1:0] typed_kind);
        bit counts;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        channel     <= c;
        level       <= l;
        span_ms     <= d;
        now_ms      <= t;
        do @(posedge clk); while (in_stall);
        // a tick with no fade running is ignored and not counted
        counts = !(k == K_TICK && !fade_on);
        advance_fader(k, c, l, d, t);
        if (typed_n == FROM_PREDICTOR)
        begin
            foreach (fresh_levels[i])
                awaited_levels.push_back(fresh_levels[i]);
        end
        else
        begin
            repeat (typed_n) awaited_levels.push_back('{typed_kind, '0, '0, 1'b1});
        end
        if (counts)
            items_done++;
    endtask

    // result side: check each transfer, then decide the stall for the next cycle
    always @(posedge clk)
    begin : result_sink
        fade_result_t got;
        fade_result_t want;
        if (out_valid && !out_stall)
        begin
            got = '{result_kind, out_channel, out_level, res_last};
            results_checked++;
            if (awaited_levels.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d ch %0d lvl %0d last %0b",
                                          got.rkind, got.ch, got.lvl, got.fin));
            else
            begin
                want = awaited_levels.pop_front();
                if (got.rkind !== want.rkind || got.ch !== want.ch ||
                    got.lvl !== want.lvl || got.fin !== want.fin)
                    report_mismatch($sformatf(
                        "kind %0d/%0d ch %0d/%0d lvl %0d/%0d last %0b/%0b (got/want)",
                        got.rkind, want.rkind, got.ch, want.ch, got.lvl, want.lvl,
                        got.fin, want.fin));
            end
        end
        // a long hold-off is counted out here so the block backs up into its input
        if (hold_given != hold_asked)
        begin
            hold_given = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    initial
    begin
        stim_row_t             r;
        logic [TIME_W-1:0]     dur;
        logic [TIME_W-1:0]     t0;
        logic [LEVEL_W-1:0]    lv;
        int                    sel;
        int                    n_ticks;
        int                    directed_taken;

        for (int i = 0; i < CHANNELS; i++)
        begin
            staged_lvl[i] = '0;
            from_lvl[i]   = '0;
            to_lvl[i]     = '0;
            shown_lvl[i]  = '0;
        end
        fade_on  = 1'b0;
        fade_t0  = '0;
        fade_len = '0;

        // directed table: typed rows carry their answer, the rest use the predictor
        // tick straight after reset, nothing is fading
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 5, NO_RESULT, RES_LEVEL));
        // durations of zero and of one under the minimum are refused
        directed_rows.push_back(stim_row(K_START, 0, 0,    0, 0, ONE_RESULT, RES_REJECTED));
        directed_rows.push_back(stim_row(K_START, 0, 0,    9, 100, ONE_RESULT, RES_REJECTED));
        // stage the extremes of level and channel
        directed_rows.push_back(stim_row(K_STAGE, 0, 1023, 0, 0, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_STAGE, 7, 1023, 0, 0, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_STAGE, 5, 10'h155, 0, 0, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_STAGE, 2, 10'h2AA, 0, 0, NO_RESULT, RES_LEVEL));
        // shortest legal fade, started at time zero; halfway tick then expiry
        directed_rows.push_back(stim_row(K_START, 0, 0,   10, 0, ONE_RESULT, RES_STARTED));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 5, FROM_PREDICTOR, RES_LEVEL));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 10, FROM_PREDICTOR, RES_LEVEL));
        // fade downwards on some channels, longest duration, clock about to wrap
        directed_rows.push_back(stim_row(K_STAGE, 0, 0,    0, 0, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_STAGE, 3, 512,  0, 0, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_START, 0, 0, '1, 32'hFFFF_FFF0, ONE_RESULT,
                                         RES_STARTED));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 32'hFFFF_FFF1, FROM_PREDICTOR,
                                         RES_LEVEL));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 32'h7FFF_FFFF, FROM_PREDICTOR,
                                         RES_LEVEL));
        // restart while fading, then a tick that runs backwards in time
        directed_rows.push_back(stim_row(K_START, 0, 0,  100, 50, ONE_RESULT, RES_STARTED));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 49, FROM_PREDICTOR, RES_LEVEL));
        // stop with every field high, later tick must stay silent
        directed_rows.push_back(stim_row(K_START, 0, 0, 1000, 0, ONE_RESULT, RES_STARTED));
        directed_rows.push_back(stim_row(K_STOP,  7, 1023, '1, '1, NO_RESULT, RES_LEVEL));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 500, NO_RESULT, RES_LEVEL));
        // a refused start also cancels the running fade
        directed_rows.push_back(stim_row(K_START, 0, 0,   30, 0, ONE_RESULT, RES_STARTED));
        directed_rows.push_back(stim_row(K_START, 0, 0,    5, 1, ONE_RESULT, RES_REJECTED));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 2, NO_RESULT, RES_LEVEL));
        // last millisecond before expiry, then expiry exactly on time
        directed_rows.push_back(stim_row(K_START, 0, 0,   20, 1000, ONE_RESULT, RES_STARTED));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 1019, FROM_PREDICTOR, RES_LEVEL));
        directed_rows.push_back(stim_row(K_TICK,  0, 0,    0, 1020, FROM_PREDICTOR, RES_LEVEL));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_item(r.kind, r.ch, r.lvl, r.dur, r.now, r.typed_n, r.typed_kind);
        end
        directed_taken = items_done;
        items_done     = 0;

        // receiver backs off for a long while as the random part opens
        hold_asked++;

        // random part: mostly whole fades with random content, some loose noise
        while (items_done < RANDOM_ITEMS)
        begin
            calm = (items_done >= 60 && items_done < 95);
            if ($urandom_range(99) < 75)
            begin
                repeat ($urandom_range(1, CHANNELS))
                begin
                    sel = $urandom_range(3);
                    lv  = (sel == 0) ? '0 : (sel == 1) ? '1 : LEVEL_W'($urandom);
                    send_item(K_STAGE, CH_W'($urandom), lv, $urandom, $urandom,
                              FROM_PREDICTOR, RES_LEVEL);
                end
                sel = $urandom_range(99);
                if (sel < 8)
                    dur = $urandom_range(0, 9);
                else if (sel < 20)
                    dur = $urandom;
                else
                    dur = $urandom_range(10, 4000);
                t0 = $urandom;
                send_item(K_START, CH_W'($urandom), LEVEL_W'($urandom), dur, t0,
                          FROM_PREDICTOR, RES_LEVEL);
                n_ticks = $urandom_range(1, 5);
                for (int j = 1; j <= n_ticks; j++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 6)
                        send_item(K_STOP, CH_W'($urandom), LEVEL_W'($urandom), $urandom,
                                  $urandom, FROM_PREDICTOR, RES_LEVEL);
                    else if (sel < 10)
                        send_item(K_TICK, CH_W'($urandom), LEVEL_W'($urandom), $urandom,
                                  t0 - TIME_W'($urandom_range(1, 1000)),
                                  FROM_PREDICTOR, RES_LEVEL);
                    else
                        send_item(K_TICK, CH_W'($urandom), LEVEL_W'($urandom), $urandom,
                                  t0 + (dur / (n_ticks + 1)) * j
                                     + TIME_W'($urandom_range(0, 3)),
                                  FROM_PREDICTOR, RES_LEVEL);
                end
                // most fades are run out; the rest are cut short by the next start
                if ($urandom_range(99) < 60)
                    send_item(K_TICK, CH_W'($urandom), LEVEL_W'($urandom), $urandom,
                              t0 + dur + TIME_W'($urandom_range(0, 50)),
                              FROM_PREDICTOR, RES_LEVEL);
            end
            else
            begin
                send_item(KIND_W'($urandom_range(0, 3)), CH_W'($urandom),
                          LEVEL_W'($urandom), $urandom, $urandom,
                          FROM_PREDICTOR, RES_LEVEL);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (awaited_levels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d directed and %0d random transfers, %0d results checked",
                 directed_taken, items_done, results_checked);
        $display("fades started %0d, refused %0d, run out %0d, mid-fade ticks %0d",
                 fades_started, starts_rejected, fades_expired, mid_ticks);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mlf_pkg.sv
rtl/mlf_level_store.sv
rtl/mlf_progress_div.sv
rtl/multichannel_linear_fade_core.sv
dv/tb_multichannel_linear_fade_core.sv
